// ===== rtl/core/osp_pkg.sv =====
// Shared types, codes and widths of the object settle and phase capture block.
package osp_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_W      = 33;
  localparam int COUNT_W    = 8;
  localparam int RUN_W      = COUNT_W + 1;
  localparam int DIST_W     = 2 * COORD_BITS + 1;
  localparam int CMP_W      = (DIST_W > CFG_W) ? DIST_W : CFG_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_REQUEST = 2'd1,
    OP_DONE    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LATCH_NONE  = 2'd0,
    LATCH_GOAL  = 2'd1,
    LATCH_START = 2'd2,
    LATCH_FINAL = 2'd3
  } latch_t;

  localparam logic [3:0] PH_GOAL   = 4'd0;
  localparam logic [3:0] PH_START  = 4'd1;
  localparam logic [3:0] PH_READY  = 4'd2;
  localparam logic [3:0] PH_MOVE   = 4'd3;
  localparam logic [3:0] PH_FINAL  = 4'd7;
  localparam logic [3:0] PH_REVIEW = 4'd8;
  localparam logic [3:0] REQ_MOVE  = 4'd3;
  localparam logic [3:0] REQ_RESET = 4'd9;

  typedef enum logic [1:0] {
    REG_MARGIN_SQ    = 2'd0,
    REG_TRAVEL_SQ    = 2'd1,
    REG_SETTLE_COUNT = 2'd2
  } reg_idx_t;

  localparam logic [CFG_W-1:0]   MARGIN_SQ_RST    = 33'd15099;
  localparam logic [CFG_W-1:0]   TRAVEL_SQ_RST    = 33'd671089;
  localparam logic [COUNT_W-1:0] SETTLE_COUNT_RST = 8'd10;

  typedef struct packed {
    logic [CFG_W-1:0]   margin_sq;
    logic [CFG_W-1:0]   travel_sq;
    logic [COUNT_W-1:0] settle_count;
  } osp_cfg_t;

endpackage

// ===== rtl/core/osp_if.sv =====
// Channel interfaces: sample input, result output and register write port.
interface osp_in_if import osp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  coord_t     pos_x;
  coord_t     pos_y;
  logic       present;
  logic [3:0] requested_phase;

  modport source (output valid, operation, pos_x, pos_y, present, requested_phase,
                  input ready);
  modport sink   (input valid, operation, pos_x, pos_y, present, requested_phase,
                  output ready);
endinterface

interface osp_out_if import osp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] phase;
  logic       settled;
  logic [1:0] latch_kind;
  coord_t     latched_x;
  coord_t     latched_y;

  modport source (output valid, phase, settled, latch_kind, latched_x, latched_y,
                  input ready);
  modport sink   (input valid, phase, settled, latch_kind, latched_x, latched_y,
                  output ready);
endinterface

interface osp_cfg_if import osp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/osp_cfg_regs.sv =====
// Configuration registers written through the register write channel.
module osp_cfg_regs import osp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  osp_cfg_if.sink   cfg,
  output osp_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.margin_sq    <= MARGIN_SQ_RST;
      regs.travel_sq    <= TRAVEL_SQ_RST;
      regs.settle_count <= SETTLE_COUNT_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_MARGIN_SQ:    regs.margin_sq    <= cfg.data;
        REG_TRAVEL_SQ:    regs.travel_sq    <= cfg.data;
        REG_SETTLE_COUNT: regs.settle_count <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/osp_dist.sv =====
// Squared Euclidean distance between two signed coordinate pairs.
module osp_dist import osp_pkg::*; (
  input  coord_t            ax,
  input  coord_t            ay,
  input  coord_t            bx,
  input  coord_t            by,
  output logic [DIST_W-1:0] sq_sum
);

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic        [COORD_BITS:0] abs_x, abs_y;
  logic        [2*COORD_BITS-1:0] sq_x, sq_y;

  always_comb begin
    diff_x = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    diff_y = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
    abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
    // The magnitude always fits in COORD_BITS unsigned bits.
    sq_x   = abs_x[COORD_BITS-1:0] * abs_x[COORD_BITS-1:0];
    sq_y   = abs_y[COORD_BITS-1:0] * abs_y[COORD_BITS-1:0];
    sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  end

endmodule

// ===== rtl/core/osp_core.sv =====
// Input register, settle tracking, phase machine and result register.
module osp_core import osp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  osp_cfg_t regs,
  osp_in_if.sink   samples,
  osp_out_if.source results
);

  // Input register.
  logic       s_valid;
  logic [1:0] s_op;
  coord_t     s_x, s_y;
  logic       s_present;
  logic [3:0] s_req;

  // Block state.
  logic [3:0]       phase;
  logic             primed;
  logic [RUN_W-1:0] close_run;
  coord_t           ref_x, ref_y, snap_x, snap_y;

  logic [3:0]       phase_next;
  logic             primed_next;
  logic [RUN_W-1:0] close_run_next;
  coord_t           ref_x_next, ref_y_next, snap_x_next, snap_y_next;

  logic             settled_next;
  latch_t           kind_next;
  coord_t           lx_next, ly_next;

  logic [DIST_W-1:0] near_dist, travel_dist;
  logic [COORD_BITS:0] sum_x, sum_y;
  logic [RUN_W-1:0] run_inc;
  logic             is_near, far_enough, proc, in_fire;

  assign proc          = s_valid && (!results.valid || results.ready);
  assign samples.ready = !s_valid || proc;
  assign in_fire       = samples.valid && samples.ready;

  osp_dist u_near (
    .ax(ref_x), .ay(ref_y), .bx(s_x), .by(s_y), .sq_sum(near_dist)
  );

  osp_dist u_travel (
    .ax(s_x), .ay(s_y), .bx(snap_x), .by(snap_y), .sq_sum(travel_dist)
  );

  always_comb begin
    is_near    = CMP_W'(near_dist) < CMP_W'(regs.margin_sq);
    far_enough = CMP_W'(travel_dist) > CMP_W'(regs.travel_sq);
    run_inc    = close_run + 1'b1;
    // Floor average is the arithmetic shift of the widened sum.
    sum_x      = {s_x[COORD_BITS-1], s_x} + {ref_x[COORD_BITS-1], ref_x};
    sum_y      = {s_y[COORD_BITS-1], s_y} + {ref_y[COORD_BITS-1], ref_y};

    phase_next     = phase;
    primed_next    = primed;
    close_run_next = close_run;
    ref_x_next     = ref_x;
    ref_y_next     = ref_y;
    snap_x_next    = snap_x;
    snap_y_next    = snap_y;
    settled_next   = 1'b0;
    kind_next      = LATCH_NONE;
    lx_next        = '0;
    ly_next        = '0;

    case (op_t'(s_op))
      OP_SAMPLE: begin
        if (!primed) begin
          ref_x_next     = s_x;
          ref_y_next     = s_y;
          primed_next    = 1'b1;
          close_run_next = '0;
        end else if (!s_present) begin
          close_run_next = '0;
        end else if (is_near) begin
          close_run_next = run_inc;
          if (run_inc > {1'b0, regs.settle_count}) begin
            close_run_next = '0;
            settled_next   = 1'b1;
            if (phase == PH_GOAL) begin
              kind_next   = LATCH_GOAL;
              snap_x_next = s_x;
              snap_y_next = s_y;
              phase_next  = PH_START;
            end else if (phase == PH_START && far_enough) begin
              kind_next  = LATCH_START;
              phase_next = PH_READY;
            end else if (phase == PH_FINAL) begin
              kind_next  = LATCH_FINAL;
              phase_next = PH_REVIEW;
            end
            if (kind_next != LATCH_NONE) begin
              lx_next = sum_x[COORD_BITS:1];
              ly_next = sum_y[COORD_BITS:1];
            end
          end
        end else begin
          ref_x_next     = s_x;
          ref_y_next     = s_y;
          close_run_next = '0;
        end
      end
      OP_REQUEST: begin
        if (phase == PH_READY && s_req == REQ_MOVE) begin
          phase_next = PH_MOVE;
        end else if (phase == PH_REVIEW && s_req == REQ_RESET) begin
          phase_next = PH_GOAL;
        end
      end
      OP_DONE: begin
        if (phase == PH_MOVE) begin
          phase_next = PH_FINAL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid       <= 1'b0;
      results.valid <= 1'b0;
      phase         <= PH_GOAL;
      primed        <= 1'b0;
      close_run     <= '0;
      ref_x         <= '0;
      ref_y         <= '0;
      snap_x        <= '0;
      snap_y        <= '0;
    end else begin
      if (in_fire) begin
        s_valid <= 1'b1;
      end else if (proc) begin
        s_valid <= 1'b0;
      end
      if (proc) begin
        results.valid <= 1'b1;
        phase         <= phase_next;
        primed        <= primed_next;
        close_run     <= close_run_next;
        ref_x         <= ref_x_next;
        ref_y         <= ref_y_next;
        snap_x        <= snap_x_next;
        snap_y        <= snap_y_next;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_op      <= samples.operation;
      s_x       <= samples.pos_x;
      s_y       <= samples.pos_y;
      s_present <= samples.present;
      s_req     <= samples.requested_phase;
    end
    if (proc) begin
      results.phase      <= phase_next;
      results.settled    <= settled_next;
      results.latch_kind <= kind_next;
      results.latched_x  <= lx_next;
      results.latched_y  <= ly_next;
    end
  end

endmodule

// ===== rtl/core/object_settle_phase_capture_top.sv =====
// Top level of the object settle and phase capture block.
//
//  Channel   Direction  Word
//  samples   in         operation, pos_x, pos_y, present, requested_phase
//  results   out        phase, settled, latch_kind, latched_x, latched_y
//  cfg       in         index, data (margin_sq, travel_sq, settle_count)
//
// One word is accepted per clock while the result channel is not stalled; a taken word goes
// from the input register through the state update to the result register once it is free.
// The throughput is set by the single state update from the input register
// to the result register.
// Reset is synchronous and clears the pipeline, the phase and the settle state,
// and loads the register defaults.
// A stalled result holds in the output register while the input register takes one more word.
module object_settle_phase_capture_top import osp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  osp_in_if.sink    samples,
  osp_out_if.source results,
  osp_cfg_if.sink   cfg
);

  osp_cfg_t regs;

  osp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  osp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .samples (samples),
    .results (results)
  );

endmodule

// ===== rtl/core/osp_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module osp_checker import osp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic [3:0]       res_phase,
  input logic             res_settled,
  input logic [1:0]       res_kind,
  input logic [COORD_BITS-1:0] res_x,
  input logic [COORD_BITS-1:0] res_y
);

  // A result word never shows up in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_no_latch_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == LATCH_NONE |-> res_x == '0 && res_y == '0)
    else $error("latched position nonzero without a latch");

  a_latch_settled: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != LATCH_NONE |-> res_settled)
    else $error("latch without a settle");

  a_latch_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      (res_kind == LATCH_NONE) ||
      (res_kind == LATCH_GOAL && res_phase == PH_START) ||
      (res_kind == LATCH_START && res_phase == PH_READY) ||
      (res_kind == LATCH_FINAL && res_phase == PH_REVIEW))
    else $error("latch kind does not match the new phase");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

endmodule

bind object_settle_phase_capture_top osp_checker u_osp_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .res_phase   (results.phase),
  .res_settled (results.settled),
  .res_kind    (results.latch_kind),
  .res_x       (results.latched_x),
  .res_y       (results.latched_y)
);
